// ===== hdl/pgtc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgtc_pkg
// Codes and constants shared by the pump guard timer controller.
// ----------------------------------------------------------------------------
package pgtc_pkg;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int OUT_TIME_W = 24;
  localparam int DEBOUNCE_W = 16;
  localparam int COOLDOWN_W = 24;
  localparam int MAX_RUN_W  = 24;
  localparam int ADDR_W     = 4;
  localparam int REG_IDX_W  = 2;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DEBOUNCED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LOCK_REJECT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_COOL_REJECT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TRIP        = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED     = 3'd5;

  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COOLDOWN = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_RUN  = 2'd2;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd500;
  localparam logic [COOLDOWN_W-1:0] COOLDOWN_RST = 24'd60000;
  localparam logic [MAX_RUN_W-1:0]  MAX_RUN_RST  = 24'd600000;
  localparam logic [OUT_TIME_W-1:0] OUT_TIME_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic                  alarm_clear;
    logic                  alarm_raise;
    logic [OUT_TIME_W-1:0] run_time_ms;
    logic [STATUS_W-1:0]   status;
    logic                  lockout;
    logic                  relay_on;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/pump_guard_timer_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pump_guard_timer_controller
// Guards a pump relay: debounce, cooldown and a run-time watchdog with lockout.
// ----------------------------------------------------------------------------
// Every input word is a tick (tuser 0), a set command (tuser 1, tdata[0] asks
// for on) or a lockout reset (tuser 2); each produces exactly one result word.
// The whole decision is one pass of compare and saturating-increment logic
// from the accepted word into the state and output registers, so a new word
// is taken every cycle while the output register is empty or being drained.
// Counters are TIME_BITS wide and saturate; the reported run time saturates
// at 24 bits. Registers (APB, byte address 4*i): debounce_ms, cooldown_ms,
// max_run_ms.
module pump_guard_timer_controller #(
  parameter int TIME_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] turn_on, [7:1] zero
  input  wire logic [1:0]  s_tuser,   // [1:0] cmd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [0] relay_on, [1] lockout, [4:2] status,
                                      // [28:5] run_time_ms, [29] alarm_raise,
                                      // [30] alarm_clear, [31] zero
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CMP_W = (TIME_BITS > 24) ? TIME_BITS : 24;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  logic [pgtc_pkg::DEBOUNCE_W-1:0] debounce_ms;
  logic [pgtc_pkg::COOLDOWN_W-1:0] cooldown_ms;
  logic [pgtc_pkg::MAX_RUN_W-1:0]  max_run_ms;

  logic                 running, running_next;
  logic                 timeout_latched, timeout_latched_next;
  logic [TIME_BITS-1:0] run_elapsed, run_elapsed_next;
  logic [TIME_BITS-1:0] since_stop, since_stop_next;
  logic [TIME_BITS-1:0] since_command, since_command_next;

  pgtc_pkg::result_t result, result_next;

  logic                            accept;
  logic                            cfg_write;
  logic [pgtc_pkg::REG_IDX_W-1:0]  reg_idx;
  logic [pgtc_pkg::CMD_W-1:0]      cmd;
  logic                            turn_on;
  logic [TIME_BITS-1:0]            run_inc, stop_inc, cmd_inc;
  logic [CMP_W-1:0]                run_ext;
  logic [pgtc_pkg::STATUS_W-1:0]   status;
  logic                            raise, clear;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      pgtc_pkg::REG_DEBOUNCE: prdata = 32'(debounce_ms);
      pgtc_pkg::REG_COOLDOWN: prdata = 32'(cooldown_ms);
      pgtc_pkg::REG_MAX_RUN:  prdata = 32'(max_run_ms);
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= pgtc_pkg::DEBOUNCE_RST;
      cooldown_ms <= pgtc_pkg::COOLDOWN_RST;
      max_run_ms  <= pgtc_pkg::MAX_RUN_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        pgtc_pkg::REG_DEBOUNCE: debounce_ms <= pwdata[pgtc_pkg::DEBOUNCE_W-1:0];
        pgtc_pkg::REG_COOLDOWN: cooldown_ms <= pwdata[pgtc_pkg::COOLDOWN_W-1:0];
        pgtc_pkg::REG_MAX_RUN:  max_run_ms  <= pwdata[pgtc_pkg::MAX_RUN_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign cmd      = s_tuser;
  assign turn_on  = s_tdata[0];

  assign run_inc  = (run_elapsed   == TIME_MAX) ? run_elapsed   : run_elapsed   + 1'b1;
  assign stop_inc = (since_stop    == TIME_MAX) ? since_stop    : since_stop    + 1'b1;
  assign cmd_inc  = (since_command == TIME_MAX) ? since_command : since_command + 1'b1;

  always_comb begin
    running_next         = running;
    timeout_latched_next = timeout_latched;
    run_elapsed_next     = run_elapsed;
    since_stop_next      = since_stop;
    since_command_next   = since_command;
    status               = pgtc_pkg::ST_OK;
    raise                = 1'b0;
    clear                = 1'b0;
    case (cmd)
      pgtc_pkg::CMD_TICK: begin
        run_elapsed_next   = run_inc;
        since_stop_next    = stop_inc;
        since_command_next = cmd_inc;
        if (running && (CMP_W'(run_inc) >= CMP_W'(max_run_ms))) begin
          running_next         = 1'b0;
          since_stop_next      = '0;
          timeout_latched_next = 1'b1;
          status               = pgtc_pkg::ST_TRIP;
          raise                = 1'b1;
        end
      end
      pgtc_pkg::CMD_SET: begin
        if (CMP_W'(since_command) < CMP_W'(debounce_ms)) begin
          status = pgtc_pkg::ST_DEBOUNCED;
        end else if (turn_on && timeout_latched) begin
          status = pgtc_pkg::ST_LOCK_REJECT;
        end else if (turn_on && !running &&
                     (CMP_W'(since_stop) < CMP_W'(cooldown_ms))) begin
          status = pgtc_pkg::ST_COOL_REJECT;
        end else begin
          since_command_next = '0;
          if (turn_on && !running) begin
            running_next     = 1'b1;
            run_elapsed_next = '0;
          end else if (!turn_on && running) begin
            running_next    = 1'b0;
            since_stop_next = '0;
          end
        end
      end
      pgtc_pkg::CMD_RESET: begin
        if (timeout_latched) begin
          timeout_latched_next = 1'b0;
          status               = pgtc_pkg::ST_CLEARED;
          clear                = 1'b1;
        end
      end
      default: ;
    endcase

    run_ext = running_next ? CMP_W'(run_elapsed_next) : '0;
    result_next.relay_on    = running_next;
    result_next.lockout     = timeout_latched_next;
    result_next.status      = status;
    result_next.run_time_ms = (run_ext > CMP_W'(pgtc_pkg::OUT_TIME_MAX)) ?
                              pgtc_pkg::OUT_TIME_MAX : run_ext[pgtc_pkg::OUT_TIME_W-1:0];
    result_next.alarm_raise = raise;
    result_next.alarm_clear = clear;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running         <= 1'b0;
      timeout_latched <= 1'b0;
      run_elapsed     <= '0;
      since_stop      <= '0;
      since_command   <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (accept) begin
        running         <= running_next;
        timeout_latched <= timeout_latched_next;
        run_elapsed     <= run_elapsed_next;
        since_stop      <= since_stop_next;
        since_command   <= since_command_next;
        m_tvalid        <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign m_tdata = {1'b0, result};

  a_raise_trip: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.alarm_raise |->
      result.status == pgtc_pkg::ST_TRIP && result.lockout && !result.relay_on)
    else $error("alarm raise without trip and lockout");

  a_clear_unlocks: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.alarm_clear |-> !result.lockout && !timeout_latched)
    else $error("alarm clear with lockout still latched");

  a_stopped_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !result.relay_on |-> result.run_time_ms == '0)
    else $error("run time reported while stopped");

  a_state_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> running == result.relay_on && timeout_latched == result.lockout)
    else $error("result word disagrees with held state");

endmodule
`default_nettype wire
